// ===== design/sm64_pkg.sv =====
// ----------------------------------------------------------------------------
// SplitMix64 range generator package
// Shared widths, constants and action codes for the generator and its
// digit-serial arithmetic units.
// ----------------------------------------------------------------------------
package sm64_pkg;

    localparam int WORD_W     = 64;
    localparam int BOUND_W    = 32;
    localparam int SPAN_W     = BOUND_W + 1;
    localparam int UNIT_W     = 53;
    localparam int UNIT_SHIFT = WORD_W - UNIT_W;
    localparam int ACTION_W   = 2;

    localparam int MUL_DIGIT_W = 16;
    localparam int MUL_STEPS   = WORD_W / MUL_DIGIT_W;
    localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
    localparam int MOD_CNT_W   = $clog2(WORD_W);

    localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

    localparam int MIX_SHIFT_A = 30;
    localparam int MIX_SHIFT_B = 27;
    localparam int MIX_SHIFT_C = 31;

    typedef enum logic [ACTION_W-1:0] {
        ACT_RAW   = 2'd0,
        ACT_UNIT  = 2'd1,
        ACT_RANGE = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

endpackage

// ===== design/sm64_mul.sv =====
// ----------------------------------------------------------------------------
// SplitMix64 digit-serial multiplier
// Forms the low 64 bits of a 64-by-64 product, one 16-bit digit of the
// second operand per cycle.
// ----------------------------------------------------------------------------
module sm64_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [sm64_pkg::WORD_W-1:0]   op_a,
    input  logic [sm64_pkg::WORD_W-1:0]   op_b,
    output logic                          done,
    output logic [sm64_pkg::WORD_W-1:0]   product
);
    import sm64_pkg::*;

    logic [WORD_W-1:0]                 a_reg, a_next;
    logic [WORD_W-1:0]                 b_reg, b_next;
    logic [WORD_W-1:0]                 acc_reg, acc_next;
    logic [MUL_CNT_W-1:0]              cnt_reg, cnt_next;
    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [WORD_W+MUL_DIGIT_W-1:0]     partial;

    assign partial = a_reg * b_reg[MUL_DIGIT_W-1:0];

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = op_a;
            b_next    = op_b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = acc_reg + partial[WORD_W-1:0];
            a_next   = a_reg << MUL_DIGIT_W;
            b_next   = b_reg >> MUL_DIGIT_W;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== design/sm64_mod.sv =====
// ----------------------------------------------------------------------------
// SplitMix64 bit-serial remainder unit
// Restoring remainder of a 64-bit dividend by a 33-bit divisor, one
// dividend bit per cycle.
// ----------------------------------------------------------------------------
module sm64_mod (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [sm64_pkg::WORD_W-1:0]   dividend,
    input  logic [sm64_pkg::SPAN_W-1:0]   divisor,
    output logic                          done,
    output logic [sm64_pkg::SPAN_W-1:0]   remainder
);
    import sm64_pkg::*;

    logic [WORD_W-1:0]    dvd_reg, dvd_next;
    logic [SPAN_W-1:0]    div_reg, div_next;
    logic [SPAN_W-1:0]    rem_reg, rem_next;
    logic [MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [SPAN_W:0]      trial;
    logic [SPAN_W:0]      diff;

    assign trial = {rem_reg, dvd_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb begin
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = dvd_reg << 1;
            if (trial >= {1'b0, div_reg}) begin
                rem_next = diff[SPAN_W-1:0];
            end else begin
                rem_next = trial[SPAN_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MOD_CNT_W'(WORD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== design/splitmix64_range_generator.sv =====
// ----------------------------------------------------------------------------
// SplitMix64 range generator
// SplitMix64 generator with raw, unit-fraction and bounded-range draws.
// ----------------------------------------------------------------------------
// The block takes one request at a time. A raw or unit draw makes two passes
// through the shared 16-bit-digit multiplier (each one load step and four
// digit steps), then takes the product and loads the output register. A
// range draw adds the bit-serial remainder (one load step and 64 dividend
// bits) before the load. A range draw with an empty range and the unused
// action code go straight to the load step without advancing the counter.
// A new request is taken while the previous result still waits in the
// output register, and a result waits in its load step for as long as the
// output register stays full. Writing the seed reloads the counter with the
// seed plus the golden gamma; write it only while no request is in flight.
module splitmix64_range_generator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sm64_pkg::WORD_W-1:0]         cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [sm64_pkg::ACTION_W-1:0]       s_action,
    input  logic signed [sm64_pkg::BOUND_W-1:0] s_range_low,
    input  logic signed [sm64_pkg::BOUND_W-1:0] s_range_high,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sm64_pkg::WORD_W-1:0]         m_raw_value,
    output logic [sm64_pkg::UNIT_W-1:0]         m_unit_fraction,
    output logic signed [sm64_pkg::BOUND_W-1:0] m_range_value
);
    import sm64_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL1 = 5'b00010,
        S_MUL2 = 5'b00100,
        S_MOD  = 5'b01000,
        S_LOAD = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [WORD_W-1:0]    counter_reg, counter_next;
    action_t              action_reg, action_next;
    logic [BOUND_W-1:0]   lo_reg, lo_next;
    logic [SPAN_W-1:0]    span_reg, span_next;
    logic [WORD_W-1:0]    res_raw_reg, res_raw_next;
    logic [BOUND_W-1:0]   res_rng_reg, res_rng_next;
    logic                 m_valid_reg, m_valid_next;
    logic [WORD_W-1:0]    m_raw_reg, m_raw_next;
    logic [UNIT_W-1:0]    m_unit_reg, m_unit_next;
    logic [BOUND_W-1:0]   m_rng_reg, m_rng_next;

    action_t              in_action;
    logic                 in_draw;
    logic [WORD_W-1:0]    cnt_adv;
    logic [SPAN_W-1:0]    in_span;
    logic [WORD_W-1:0]    mixed;

    logic                 mul_start;
    logic [WORD_W-1:0]    mul_a;
    logic [WORD_W-1:0]    mul_b;
    logic                 mul_done;
    logic [WORD_W-1:0]    mul_p;
    logic                 mod_start;
    logic                 mod_done;
    logic [SPAN_W-1:0]    mod_rem;

    sm64_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    sm64_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (mixed),
        .divisor   (span_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign in_action = action_t'(s_action);
    assign cnt_adv   = counter_reg + GOLDEN_GAMMA;
    assign in_span   = {s_range_high[BOUND_W-1], s_range_high}
                     - {s_range_low[BOUND_W-1], s_range_low} + SPAN_W'(1);
    assign mixed     = mul_p ^ (mul_p >> MIX_SHIFT_C);

    always_comb begin
        in_draw = 1'b0;
        if (in_action inside {ACT_RAW, ACT_UNIT}) begin
            in_draw = 1'b1;
        end else if (in_action == ACT_RANGE) begin
            in_draw = (s_range_high > s_range_low);
        end
    end

    always_comb begin
        state_next   = state_reg;
        counter_next = counter_reg;
        action_next  = action_reg;
        lo_next      = lo_reg;
        span_next    = span_reg;
        res_raw_next = res_raw_reg;
        res_rng_next = res_rng_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        m_raw_next   = m_raw_reg;
        m_unit_next  = m_unit_reg;
        m_rng_next   = m_rng_reg;
        mul_start    = 1'b0;
        mul_a        = cnt_adv ^ (cnt_adv >> MIX_SHIFT_A);
        mul_b        = MIX_MUL_A;
        mod_start    = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    action_next = in_action;
                    lo_next     = s_range_low;
                    span_next   = in_span;
                    if (in_draw) begin
                        counter_next = cnt_adv;
                        mul_start    = 1'b1;
                        state_next   = S_MUL1;
                    end else begin
                        res_raw_next = '0;
                        res_rng_next = (in_action == ACT_RANGE) ? s_range_low : '0;
                        state_next   = S_LOAD;
                    end
                end
            end
            S_MUL1: begin
                mul_a = mul_p ^ (mul_p >> MIX_SHIFT_B);
                mul_b = MIX_MUL_B;
                if (mul_done) begin
                    mul_start  = 1'b1;
                    state_next = S_MUL2;
                end
            end
            S_MUL2: begin
                if (mul_done) begin
                    res_raw_next = mixed;
                    res_rng_next = '0;
                    if (action_reg == ACT_RANGE) begin
                        mod_start  = 1'b1;
                        state_next = S_MOD;
                    end else begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    res_rng_next = lo_reg + mod_rem[BOUND_W-1:0];
                    state_next   = S_LOAD;
                end
            end
            S_LOAD: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_raw_next   = res_raw_reg;
                    m_unit_next  = (action_reg == ACT_UNIT) ?
                                   res_raw_reg[WORD_W-1:UNIT_SHIFT] : '0;
                    m_rng_next   = res_rng_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid) begin
            counter_next = cfg_data + GOLDEN_GAMMA;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            counter_reg <= GOLDEN_GAMMA;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            counter_reg <= counter_next;
            m_valid_reg <= m_valid_next;
        end
        action_reg  <= action_next;
        lo_reg      <= lo_next;
        span_reg    <= span_next;
        res_raw_reg <= res_raw_next;
        res_rng_reg <= res_rng_next;
        m_raw_reg   <= m_raw_next;
        m_unit_reg  <= m_unit_next;
        m_rng_reg   <= m_rng_next;
    end

    assign cfg_ready       = 1'b1;
    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_raw_value     = m_raw_reg;
    assign m_unit_fraction = m_unit_reg;
    assign m_range_value   = m_rng_reg;

    // The shared multiplier only finishes while a mixing pass waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == S_MUL1 || state_reg == S_MUL2))
        else $error("multiplier finished outside a mixing state");

    // A finished remainder is always below the span it was taken against.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> (state_reg == S_MOD && mod_rem < span_reg))
        else $error("remainder out of range or unexpected");

    // A request that does not draw leaves the counter untouched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !in_draw && !cfg_valid) |=> $stable(counter_reg))
        else $error("counter advanced on a request without a draw");

    // A result transfer always returns the block to waiting for a request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LOAD && (!m_valid_reg || m_ready)) |=>
            (m_valid_reg && state_reg == S_IDLE))
        else $error("result load did not complete");

endmodule

// ===== tb/splitmix64_range_generator_test.sv =====
// ----------------------------------------------------------------------------
// SplitMix64 range generator testbench
// Drives raw, unit, range and unused-action requests through the request
// channel under random sender bursts and receiver stalls, rewrites the seed
// between phases, and checks every result transfer against the generator predictor or a typed result.
// ----------------------------------------------------------------------------
module splitmix64_range_generator_test;

    import sm64_pkg::*;

    localparam logic [WORD_W-1:0] GAMMA_STEP = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] MIX_A      = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [WORD_W-1:0] MIX_B      = 64'h94D0_49BB_1331_11EB;

    localparam logic signed [BOUND_W-1:0] B_MIN = 32'sh8000_0000;
    localparam logic signed [BOUND_W-1:0] B_MAX = 32'sh7FFF_FFFF;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_ITEMS  = 200;
    localparam int PHASE_COUNT  = 7;
    localparam int SETTLE_TICKS = 100;

    typedef struct packed {
        logic [WORD_W-1:0]         raw;
        logic [UNIT_W-1:0]         unit;
        logic signed [BOUND_W-1:0] rng;
    } draw_result_t;

    typedef struct packed {
        action_t                   act;
        logic signed [BOUND_W-1:0] lo;
        logic signed [BOUND_W-1:0] hi;
        logic                      typed;
        draw_result_t              want;
    } stim_row_t;

    localparam draw_result_t ZERO_RESULT = '0;
    localparam int DIR_COUNT = 23;

    // Rows with typed results are the empty ranges and the unused action code.
    localparam stim_row_t DIRECTED_ROWS [DIR_COUNT] = '{
        '{ACT_RAW,   32'sd0,        32'sd0,        1'b0, ZERO_RESULT},
        '{ACT_UNIT,  32'sd0,        32'sd0,        1'b0, ZERO_RESULT},
        '{ACT_RAW,   B_MIN,         B_MAX,         1'b0, ZERO_RESULT},
        '{ACT_UNIT,  B_MAX,         B_MIN,         1'b0, ZERO_RESULT},
        '{ACT_RANGE, 32'sd0,        32'sd9,        1'b0, ZERO_RESULT},
        '{ACT_RANGE, B_MIN,         B_MAX,         1'b0, ZERO_RESULT},
        '{ACT_RANGE, B_MIN,         32'sh8000_0001, 1'b0, ZERO_RESULT},
        '{ACT_RANGE, 32'sh7FFF_FFFE, B_MAX,        1'b0, ZERO_RESULT},
        '{ACT_RANGE, -32'sd1,       32'sd0,        1'b0, ZERO_RESULT},
        '{ACT_RANGE, -32'sd10,      32'sd10,       1'b0, ZERO_RESULT},
        '{ACT_RANGE, 32'sd0,        32'sd1,        1'b0, ZERO_RESULT},
        '{ACT_RANGE, B_MIN,         32'sd0,        1'b0, ZERO_RESULT},
        '{ACT_RANGE, 32'sd1,        B_MAX,         1'b0, ZERO_RESULT},
        '{ACT_RANGE, 32'sd5,        32'sd5,        1'b1, '{64'd0, 53'd0, 32'sd5}},
        '{ACT_RANGE, B_MAX,         B_MIN,         1'b1, '{64'd0, 53'd0, B_MAX}},
        '{ACT_RANGE, 32'sd0,        -32'sd1,       1'b1, '{64'd0, 53'd0, 32'sd0}},
        '{ACT_RANGE, B_MIN,         B_MIN,         1'b1, '{64'd0, 53'd0, B_MIN}},
        '{ACT_RANGE, B_MAX,         B_MAX,         1'b1, '{64'd0, 53'd0, B_MAX}},
        '{ACT_NONE,  32'sd0,        32'sd0,        1'b1, ZERO_RESULT},
        '{ACT_NONE,  B_MIN,         B_MAX,         1'b1, ZERO_RESULT},
        '{ACT_NONE,  -32'sd1,       -32'sd1,       1'b1, ZERO_RESULT},
        '{ACT_UNIT,  -32'sd1,       -32'sd1,       1'b0, ZERO_RESULT},
        '{ACT_RANGE, -32'sd1,       B_MAX,         1'b0, ZERO_RESULT}
    };

    localparam logic [WORD_W-1:0] FIXED_SEEDS [5] = '{
        64'h0000_0000_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'h0000_0000_0000_0001,
        64'h61C8_8646_80B5_83EB,
        64'h8000_0000_0000_0000
    };

    logic                        aclk            = 1'b0;
    logic                        aresetn         = 1'b0;
    logic                        cfg_valid       = 1'b0;
    logic                        cfg_ready;
    logic [WORD_W-1:0]           cfg_data        = '0;
    logic                        s_valid         = 1'b0;
    logic                        s_ready;
    logic [ACTION_W-1:0]         s_action        = '0;
    logic signed [BOUND_W-1:0]   s_range_low     = '0;
    logic signed [BOUND_W-1:0]   s_range_high    = '0;
    logic                        m_valid;
    logic                        m_ready         = 1'b0;
    logic [WORD_W-1:0]           m_raw_value;
    logic [UNIT_W-1:0]           m_unit_fraction;
    logic signed [BOUND_W-1:0]   m_range_value;

    logic [WORD_W-1:0] gen_counter = GAMMA_STEP;
    draw_result_t      pending_draws [$];
    draw_result_t      head_result;
    int unsigned       error_count = 0;
    int unsigned       cycle_count = 0;

    splitmix64_range_generator u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_range_low     (s_range_low),
        .s_range_high    (s_range_high),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_raw_value     (m_raw_value),
        .m_unit_fraction (m_unit_fraction),
        .m_range_value   (m_range_value)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] mix64(input logic [WORD_W-1:0] z);
        z = (z ^ (z >> 30)) * MIX_A;
        z = (z ^ (z >> 27)) * MIX_B;
        return z ^ (z >> 31);
    endfunction

    // Works out the result of one request and advances the counter when the
    // request draws a value.
    function automatic draw_result_t predict_draw(
        input action_t                   act,
        input logic signed [BOUND_W-1:0] lo,
        input logic signed [BOUND_W-1:0] hi
    );
        draw_result_t      r;
        logic [SPAN_W-1:0] span;
        logic [WORD_W-1:0] rem;
        r = '0;
        case (act)
            ACT_RAW: begin
                gen_counter = gen_counter + GAMMA_STEP;
                r.raw = mix64(gen_counter);
            end
            ACT_UNIT: begin
                gen_counter = gen_counter + GAMMA_STEP;
                r.raw  = mix64(gen_counter);
                r.unit = r.raw[WORD_W-1:WORD_W-UNIT_W];
            end
            ACT_RANGE: begin
                if (hi > lo) begin
                    span = {hi[BOUND_W-1], hi} - {lo[BOUND_W-1], lo} + 1'b1;
                    gen_counter = gen_counter + GAMMA_STEP;
                    r.raw = mix64(gen_counter);
                    rem   = r.raw % {{(WORD_W-SPAN_W){1'b0}}, span};
                    r.rng = lo + rem[BOUND_W-1:0];
                end else begin
                    r.rng = lo;
                end
            end
            default: begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("ERROR cycle %0d: %s got %h want %h", cycle_count, field, got, want);
        error_count++;
    endtask

    task automatic send_request(input action_t act, input logic signed [BOUND_W-1:0] lo,
                                input logic signed [BOUND_W-1:0] hi, input logic typed,
                                input draw_result_t want);
        draw_result_t predicted;
        @(negedge aclk);
        s_valid      = 1'b1;
        s_action     = act;
        s_range_low  = lo;
        s_range_high = hi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = predict_draw(act, lo, hi);
        pending_draws.push_back(typed ? want : predicted);
    endtask

    task automatic idle_sender(input int ticks);
        if (ticks > 0) begin
            @(negedge aclk);
            s_valid      = 1'b0;
            s_action     = ACTION_W'($urandom);
            s_range_low  = $urandom;
            s_range_high = $urandom;
            repeat (ticks - 1) @(negedge aclk);
        end
    endtask

    task automatic drain_results;
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_draws.size() != 0) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [WORD_W-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        gen_counter = value + GAMMA_STEP;
        @(negedge aclk);
        cfg_valid = 1'b0;
        cfg_data  = {$urandom, $urandom};
    endtask

    task automatic random_request(output action_t act, output logic signed [BOUND_W-1:0] lo,
                                  output logic signed [BOUND_W-1:0] hi);
        int pick;
        pick = $urandom_range(0, 99);
        lo   = $urandom;
        hi   = $urandom;
        if (pick < 25) begin
            act = ACT_RAW;
        end else if (pick < 50) begin
            act = ACT_UNIT;
        end else if (pick < 92) begin
            act = ACT_RANGE;
            case ($urandom_range(0, 4))
                0: begin
                    hi = $urandom;
                end
                1: begin
                    hi = lo + $urandom_range(0, 1000);
                end
                2: begin
                    lo = $urandom_range(0, 40) - 20;
                    hi = lo + $urandom_range(0, 12);
                end
                3: begin
                    lo = B_MIN + $urandom_range(0, 2);
                    hi = B_MAX - $urandom_range(0, 2);
                end
                default: begin
                    hi = lo - $urandom_range(0, 2);
                end
            endcase
        end else begin
            act = ACT_NONE;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_draws.size() == 0) begin
                report_mismatch("unexpected m_raw_value", m_raw_value, '0);
            end else begin
                head_result = pending_draws.pop_front();
                if (m_raw_value !== head_result.raw)
                    report_mismatch("m_raw_value", m_raw_value, head_result.raw);
                if (m_unit_fraction !== head_result.unit)
                    report_mismatch("m_unit_fraction", WORD_W'(m_unit_fraction),
                                    WORD_W'(head_result.unit));
                if (m_range_value !== head_result.rng)
                    report_mismatch("m_range_value", WORD_W'(m_range_value),
                                    WORD_W'(head_result.rng));
            end
        end
    end

    // The receiver switches between free running, light stalls and heavy stalls.
    initial begin
        int stall_mode;
        int mode_left;
        int stall_left;
        stall_mode = 0;
        mode_left  = 0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(50, 300);
            end
            mode_left--;
            if (stall_left != 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                m_ready = 1'b1;
                if ((stall_mode == 1 && $urandom_range(0, 3) == 0) ||
                    (stall_mode == 2 && $urandom_range(0, 3) != 0)) begin
                    stall_left = $urandom_range(1, 8);
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk) cycle_count++;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int                        row;
        int                        phase;
        int                        item;
        int                        burst_left;
        action_t                   act;
        logic signed [BOUND_W-1:0] lo;
        logic signed [BOUND_W-1:0] hi;
        logic [WORD_W-1:0]         phase_seed;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (row = 0; row < DIR_COUNT; row++) begin
            if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 4));
            send_request(DIRECTED_ROWS[row].act, DIRECTED_ROWS[row].lo,
                         DIRECTED_ROWS[row].hi, DIRECTED_ROWS[row].typed,
                         DIRECTED_ROWS[row].want);
        end
        drain_results;

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            phase_seed = (phase < 5) ? FIXED_SEEDS[phase] : {$urandom, $urandom};
            write_seed(phase_seed);
            burst_left = 0;
            for (item = 0; item < PHASE_ITEMS; item++) begin
                if (burst_left == 0) begin
                    idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
                    burst_left = $urandom_range(1, 12);
                end
                if ($urandom_range(0, 149) == 0) drain_results;
                random_request(act, lo, hi);
                send_request(act, lo, hi, 1'b0, ZERO_RESULT);
                burst_left--;
            end
            drain_results;
        end

        repeat (SETTLE_TICKS) @(posedge aclk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
